### sv/cstt_pkg.sv
// Shared types, character codes and the window decision function of the
// C source translator (trigraphs, line splices, digraphs). No dependencies.
package cstt_pkg;

    localparam int LINE_BITS    = 24;
    localparam int COLUMN_BITS  = 16;
    localparam int WIN_DEPTH    = 5;
    localparam int WIN_IDX_BITS = 3;
    localparam int QDEPTH       = 4;
    localparam int QPTR_BITS    = 2;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_APOS    = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_BSL     = 8'h5C;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_TILDE   = 8'h7E;

    typedef struct packed {
        logic [7:0] src_byte;
        logic       end_of_source;
    } in_item_t;

    typedef struct packed {
        logic [7:0]             out_byte;
        logic [LINE_BITS-1:0]   raw_line;
        logic [COLUMN_BITS-1:0] raw_column;
        logic                   is_terminator;
        logic                   trigraph_seen;
        logic                   last_of_run;
    } result_t;

    typedef logic [WIN_DEPTH-1:0][7:0] window_t;

    typedef struct packed {
        logic [WIN_IDX_BITS-1:0] used;
        logic [1:0]              nres;
        logic [7:0]              b0;
        logic [7:0]              b1;
        logic                    trig;
    } decision_t;

    // one queued record: one or two character results, or the terminator
    typedef struct packed {
        logic [7:0]             b0;
        logic [7:0]             b1;
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] col;
        logic [COLUMN_BITS-1:0] col2;
        logic                   two;
        logic                   term;
        logic                   seen;
        logic                   last;
    } entry_t;

    typedef enum logic {
        FE_RUN,
        FE_FLUSH
    } front_state_t;

    function automatic logic [7:0] tri_map(input logic [7:0] b);
        logic [7:0] m;
        case (b)
            CH_EQ:     m = CH_HASH;
            CH_SLASH:  m = CH_BSL;
            CH_APOS:   m = CH_CARET;
            CH_LT:     m = CH_LBRACE;
            CH_GT:     m = CH_RBRACE;
            CH_BANG:   m = CH_BAR;
            CH_LPAREN: m = CH_LBRACK;
            CH_RPAREN: m = CH_RBRACK;
            CH_MINUS:  m = CH_TILDE;
            default:   m = CH_NUL;
        endcase
        return m;
    endfunction

    // One decision at the window head; bytes at or beyond avail are never tested.
    function automatic decision_t decide(input window_t w,
                                         input logic [WIN_IDX_BITS-1:0] avail,
                                         input logic en);
        decision_t  d;
        logic [7:0] tm;
        logic       tri_hit;
        d.used  = WIN_IDX_BITS'(1);
        d.nres  = 2'd1;
        d.b0    = w[0];
        d.b1    = w[0];
        d.trig  = 1'b0;
        tm      = tri_map(w[2]);
        tri_hit = en && (avail >= WIN_IDX_BITS'(3)) && (w[0] == CH_QMARK)
                  && (w[1] == CH_QMARK) && (tm != CH_NUL);
        if (tri_hit)
        begin
            d.trig = 1'b1;
            if ((tm == CH_BSL) && (avail >= WIN_IDX_BITS'(4)) && (w[3] == CH_LF))
            begin
                d.used = WIN_IDX_BITS'(4);
                d.nres = 2'd0;
            end
            else if ((tm == CH_BSL) && (avail >= WIN_IDX_BITS'(5)) && (w[3] == CH_CR)
                     && (w[4] == CH_LF))
            begin
                d.used = WIN_IDX_BITS'(5);
                d.nres = 2'd0;
            end
            else
            begin
                d.used = WIN_IDX_BITS'(3);
                d.b0   = tm;
            end
        end
        else if ((w[0] == CH_BSL) && (avail >= WIN_IDX_BITS'(2)) && (w[1] == CH_LF))
        begin
            d.used = WIN_IDX_BITS'(2);
            d.nres = 2'd0;
        end
        else if ((w[0] == CH_BSL) && (avail >= WIN_IDX_BITS'(3)) && (w[1] == CH_CR)
                 && (w[2] == CH_LF))
        begin
            d.used = WIN_IDX_BITS'(3);
            d.nres = 2'd0;
        end
        else if ((avail >= WIN_IDX_BITS'(4)) && (w[0] == CH_PERCENT) && (w[1] == CH_COLON)
                 && (w[2] == CH_PERCENT) && (w[3] == CH_COLON))
        begin
            d.used = WIN_IDX_BITS'(4);
            d.nres = 2'd2;
            d.b0   = CH_HASH;
            d.b1   = CH_HASH;
        end
        else if (avail >= WIN_IDX_BITS'(2))
        begin
            if ((w[0] == CH_PERCENT) && (w[1] == CH_COLON))
            begin
                d.used = WIN_IDX_BITS'(2);
                d.b0   = CH_HASH;
            end
            else if ((w[0] == CH_LT) && (w[1] == CH_COLON))
            begin
                d.used = WIN_IDX_BITS'(2);
                d.b0   = CH_LBRACK;
            end
            else if ((w[0] == CH_COLON) && (w[1] == CH_GT))
            begin
                d.used = WIN_IDX_BITS'(2);
                d.b0   = CH_RBRACK;
            end
            else if ((w[0] == CH_LT) && (w[1] == CH_PERCENT))
            begin
                d.used = WIN_IDX_BITS'(2);
                d.b0   = CH_LBRACE;
            end
            else if ((w[0] == CH_PERCENT) && (w[1] == CH_GT))
            begin
                d.used = WIN_IDX_BITS'(2);
                d.b0   = CH_RBRACE;
            end
        end
        return d;
    endfunction

endpackage

### sv/cstt_front.sv
// Front end: five-byte lookahead window, translation decision and raw position.
// Pushes result records into the queue. Depends on cstt_pkg.
module cstt_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cstt_pkg::in_item_t  src,
    output logic                full,
    input  logic                trig_en,
    output logic                q_push,
    output cstt_pkg::entry_t    q_entry,
    input  logic                q_full
);

    localparam int LB = cstt_pkg::LINE_BITS;
    localparam int CB = cstt_pkg::COLUMN_BITS;
    localparam int WB = cstt_pkg::WIN_IDX_BITS;
    localparam int WD = cstt_pkg::WIN_DEPTH;

    cstt_pkg::front_state_t state_reg, state_next;
    cstt_pkg::window_t      win_reg, win_next;
    logic [WB-1:0]          count_reg, count_next;
    logic [LB-1:0]          line_reg, line_next;
    logic [CB-1:0]          col_reg, col_next;
    logic                   seen_reg, seen_next;

    cstt_pkg::window_t      win_app, win_sel, win_sh;
    cstt_pkg::decision_t    dec;
    logic [WB-1:0]          avail;
    logic                   accept, byte_acc, end_acc, do_dec, term_push, lf_end;
    logic [7:0]             last_byte;
    logic [LB-1:0]          line_inc;
    logic [CB:0]            col_sum, col_sum2;
    logic [CB-1:0]          col_adv, col2;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cstt_pkg::FE_RUN:
            begin
                if (end_acc)
                    state_next = cstt_pkg::FE_FLUSH;
            end
            cstt_pkg::FE_FLUSH:
            begin
                if (term_push)
                    state_next = cstt_pkg::FE_RUN;
            end
            default: state_next = cstt_pkg::FE_RUN;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            cstt_pkg::FE_RUN: full = q_full;
            default:          full = 1'b1;
        endcase
    end

    always_comb
    begin
        accept   = push && !full;
        byte_acc = accept && !src.end_of_source;
        end_acc  = accept && src.end_of_source;

        win_app            = win_reg;
        win_app[count_reg] = src.src_byte;

        if (state_reg == cstt_pkg::FE_RUN)
        begin
            win_sel = win_app;
            avail   = WB'(WD);
            do_dec  = byte_acc && (count_reg == WB'(WD - 1));
        end
        else
        begin
            win_sel = win_reg;
            avail   = count_reg;
            do_dec  = !q_full && (count_reg != '0);
        end
        term_push = (state_reg == cstt_pkg::FE_FLUSH) && !q_full && (count_reg == '0);

        dec = cstt_pkg::decide(win_sel, avail, trig_en);

        // only the last consumed byte can be a line feed
        last_byte = win_sel[0];
        for (int k = 2; k <= WD; k++)
        begin
            if (dec.used == WB'(k))
                last_byte = win_sel[k-1];
        end
        lf_end = (last_byte == cstt_pkg::CH_LF);

        win_sh = win_sel;
        for (int i = 0; i < WD; i++)
        begin
            for (int k = 1; k <= WD; k++)
            begin
                if ((dec.used == WB'(k)) && (i + k < WD))
                    win_sh[i] = win_sel[i+k];
            end
        end

        line_inc = (line_reg == '1) ? line_reg : line_reg + LB'(1);
        col_sum  = {1'b0, col_reg} + (CB+1)'(dec.used);
        col_adv  = col_sum[CB] ? '1 : col_sum[CB-1:0];
        col_sum2 = {1'b0, col_reg} + (CB+1)'(2);
        col2     = col_sum2[CB] ? '1 : col_sum2[CB-1:0];

        win_next   = win_reg;
        count_next = count_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        seen_next  = seen_reg;
        if (byte_acc)
        begin
            win_next   = win_app;
            count_next = count_reg + WB'(1);
        end
        if (do_dec)
        begin
            win_next   = win_sh;
            count_next = avail - dec.used;
            line_next  = lf_end ? line_inc : line_reg;
            col_next   = lf_end ? CB'(1) : col_adv;
            if (dec.trig)
                seen_next = 1'b1;
        end
        if (term_push)
        begin
            count_next = '0;
            line_next  = LB'(1);
            col_next   = CB'(1);
            seen_next  = 1'b0;
        end

        q_push        = (do_dec && (dec.nres != 2'd0)) || term_push;
        q_entry.b0    = term_push ? cstt_pkg::CH_NUL : dec.b0;
        q_entry.b1    = dec.b1;
        q_entry.line  = line_reg;
        q_entry.col   = col_reg;
        q_entry.col2  = col2;
        q_entry.two   = (dec.nres == 2'd2) && !term_push;
        q_entry.term  = term_push;
        q_entry.seen  = term_push && seen_reg;
        // a byte request makes at most one decision, so its record ends the run
        q_entry.last  = term_push || (state_reg == cstt_pkg::FE_RUN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cstt_pkg::FE_RUN;
            count_reg <= '0;
            line_reg  <= LB'(1);
            col_reg   <= CB'(1);
            seen_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

### sv/cstt_fifo.sv
// Short record queue between the front and back ends.
// Depends on cstt_pkg.
module cstt_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  cstt_pkg::entry_t  wr_data,
    output logic              full,
    input  logic              rd_en,
    output cstt_pkg::entry_t  rd_data,
    output logic              empty
);

    localparam int PB = cstt_pkg::QPTR_BITS;

    cstt_pkg::entry_t mem [cstt_pkg::QDEPTH];
    logic [PB-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PB-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PB:0]      count_reg, count_next;
    logic             do_wr, do_rd;

    always_comb
    begin
        full  = (count_reg == (PB+1)'(cstt_pkg::QDEPTH));
        empty = (count_reg == '0);
        do_wr = wr_en && !full;
        do_rd = rd_en && !empty;
        // depth is a power of two, pointers wrap on their own
        wr_ptr_next = do_wr ? wr_ptr_reg + PB'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + PB'(1) : rd_ptr_reg;
        count_next  = count_reg + (PB+1)'(do_wr) - (PB+1)'(do_rd);
        rd_data     = mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

### sv/cstt_back.sv
// Back end: output register that expands queued records into result requests.
// Depends on cstt_pkg.
module cstt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  cstt_pkg::entry_t  q_data,
    input  logic              q_empty,
    output logic              q_pop,
    output cstt_pkg::result_t result,
    output logic              empty,
    input  logic              pop
);

    cstt_pkg::entry_t cur_reg, cur_next;
    logic             valid_reg, valid_next;
    logic             half_reg, half_next;
    logic             advance;

    always_comb
    begin
        advance    = !valid_reg || (pop && (!cur_reg.two || half_reg));
        q_pop      = advance && !q_empty;
        cur_next   = cur_reg;
        valid_next = valid_reg;
        half_next  = half_reg;
        if (advance)
        begin
            valid_next = !q_empty;
            cur_next   = q_data;
            half_next  = 1'b0;
        end
        else if (pop)
        begin
            // first half of a %:%: pair taken, show the second #
            half_next = 1'b1;
        end

        empty                = !valid_reg;
        result.out_byte      = half_reg ? cur_reg.b1 : cur_reg.b0;
        result.raw_line      = cur_reg.line;
        result.raw_column    = half_reg ? cur_reg.col2 : cur_reg.col;
        result.is_terminator = cur_reg.term;
        result.trigraph_seen = cur_reg.seen;
        result.last_of_run   = cur_reg.last && (!cur_reg.two || half_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

### sv/c_source_trigraph_splice_translator_top.sv
// Top level of the C source translator: config register, front end, record
// queue, back end. Depends on cstt_pkg, cstt_front, cstt_fifo, cstt_back.
//
// Input channel: raw source bytes, one per request (push while full is low).
// A request with end_of_source set flushes the lookahead window and yields a
// terminator record with the final raw position and the trigraph flag.
// Result channel: oldest result shown while empty is low, taken with pop.
// Throughput: one byte per cycle while full is low; the window decision is combinational
// in the front end. The record for a decision is written into the queue when the byte
// that completes it is taken, then shown from the back output register. %:%: yields two
// results, shown one per cycle by the back end while pop is high.
// An end request holds full high while the remaining decisions (at most four) and the
// terminator are pushed, then the window and position reset.
// When the receiver stalls, the four-record queue absorbs the front end's
// output; full rises once it is filled, the shown result holds.
// Reset clears the window count, position, flags and queue; trigraph
// translation is off until cfg_data is written with cfg_we.
module c_source_trigraph_splice_translator_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cstt_pkg::in_item_t src,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output cstt_pkg::result_t  result,
    input  logic               cfg_we,
    input  logic               cfg_data
);

    logic             trig_en_reg;
    logic             q_push, q_full, q_pop, q_empty;
    cstt_pkg::entry_t q_entry, q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            trig_en_reg <= 1'b0;
        else if (cfg_we)
            trig_en_reg <= cfg_data;
    end

    cstt_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .src     (src),
        .full    (full),
        .trig_en (trig_en_reg),
        .q_push  (q_push),
        .q_entry (q_entry),
        .q_full  (q_full)
    );

    cstt_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_entry),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    cstt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_data),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

### sv/cstt_checker.sv
// Port-level checks for the C source translator, bound to the top level.
// Depends on cstt_pkg and c_source_trigraph_splice_translator_top.
module cstt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input cstt_pkg::in_item_t src,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input cstt_pkg::result_t  result
);

    // terminator carries a zero byte and always closes its run
    a_term_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.is_terminator)
        |-> (result.out_byte == cstt_pkg::CH_NUL && result.last_of_run))
        else $error("terminator record malformed");

    a_seen_only_on_term: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.is_terminator) |-> !result.trigraph_seen)
        else $error("trigraph flag on a character result");

    a_position_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.raw_line != '0 && result.raw_column != '0))
        else $error("raw position is zero");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("stalled result changed");

    // the window flush always holds full high right after an accepted end request
    a_end_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && src.end_of_source) |=> full)
        else $error("request accepted right after an end request");

endmodule

bind c_source_trigraph_splice_translator_top cstt_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .src      (src),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
);

### sim/tb_top.sv
// Testbench for c_source_trigraph_splice_translator_top: self-checking, with its own
// translation predictor, a random-gap request driver and a random-stall result checker.
// Depends on cstt_pkg and the translator RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int LB = cstt_pkg::LINE_BITS;
    localparam int CB = cstt_pkg::COLUMN_BITS;
    localparam int WD = cstt_pkg::WIN_DEPTH;
    localparam logic [LB-1:0] LINE_MAX = '1;
    localparam logic [CB-1:0] COL_MAX  = '1;
    localparam int RANDOM_ITEMS = 280;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    cstt_pkg::in_item_t src = '0;
    logic               full;
    logic               empty;
    logic               pop = 1'b0;
    cstt_pkg::result_t  result;
    logic               cfg_we = 1'b0;
    logic               cfg_data = 1'b0;

    c_source_trigraph_splice_translator_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .src      (src),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor state
    logic [7:0]    pred_win [WD] = '{default: 8'h00};
    int            win_cnt = 0;
    logic [LB-1:0] p_line = LB'(1);
    logic [CB-1:0] p_col = CB'(1);
    bit            p_seen = 1'b0;
    bit            tri_en = 1'b0;

    cstt_pkg::result_t  step_res [$];
    cstt_pkg::result_t  translated_q [$];
    cstt_pkg::in_item_t pending_q [$];

    bit steady = 1'b0;
    int queued = 0;
    int items_accepted = 0;
    int sources_done = 0;
    int seen_terms = 0;
    int results_checked = 0;
    int err_count = 0;
    int cfg_writes = 0;
    int drv_gap = 0;
    int rcv_gap = 0;
    int hold_cnt = 0;
    bit hold_done = 1'b0;
    bit hold_arm = 1'b0;

    logic [7:0] tri_keys [9] = '{cstt_pkg::CH_EQ, cstt_pkg::CH_SLASH, cstt_pkg::CH_APOS,
                                 cstt_pkg::CH_LT, cstt_pkg::CH_GT, cstt_pkg::CH_BANG,
                                 cstt_pkg::CH_LPAREN, cstt_pkg::CH_RPAREN,
                                 cstt_pkg::CH_MINUS};
    logic [7:0] digraph_text [5][2] = '{'{cstt_pkg::CH_PERCENT, cstt_pkg::CH_COLON},
                                       '{cstt_pkg::CH_LT, cstt_pkg::CH_COLON},
                                       '{cstt_pkg::CH_COLON, cstt_pkg::CH_GT},
                                       '{cstt_pkg::CH_LT, cstt_pkg::CH_PERCENT},
                                       '{cstt_pkg::CH_PERCENT, cstt_pkg::CH_GT}};

    function automatic logic [7:0] trigraph_char(input logic [7:0] c);
        case (c)
            cstt_pkg::CH_EQ:     return cstt_pkg::CH_HASH;
            cstt_pkg::CH_SLASH:  return cstt_pkg::CH_BSL;
            cstt_pkg::CH_APOS:   return cstt_pkg::CH_CARET;
            cstt_pkg::CH_LT:     return cstt_pkg::CH_LBRACE;
            cstt_pkg::CH_GT:     return cstt_pkg::CH_RBRACE;
            cstt_pkg::CH_BANG:   return cstt_pkg::CH_BAR;
            cstt_pkg::CH_LPAREN: return cstt_pkg::CH_LBRACK;
            cstt_pkg::CH_RPAREN: return cstt_pkg::CH_RBRACK;
            cstt_pkg::CH_MINUS:  return cstt_pkg::CH_TILDE;
            default:             return cstt_pkg::CH_NUL;
        endcase
    endfunction

    function automatic logic [CB-1:0] col_plus(input logic [CB-1:0] c, input int k);
        logic [CB:0] s;
        s = {1'b0, c} + (CB+1)'(k);
        return (s > {1'b0, COL_MAX}) ? COL_MAX : s[CB-1:0];
    endfunction

    function automatic void add_result(input logic [7:0] b, input logic [CB-1:0] col,
                                       input bit term, input bit seen);
        cstt_pkg::result_t r;
        r.out_byte      = b;
        r.raw_line      = p_line;
        r.raw_column    = col;
        r.is_terminator = term;
        r.trigraph_seen = seen;
        r.last_of_run   = 1'b0;
        step_res.push_back(r);
    endfunction

    // drop n bytes from the window head, advancing the raw position
    function automatic void shift_out(input int n);
        int m;
        int i;
        m = (n > win_cnt) ? win_cnt : n;
        for (i = 0; i < m; i++)
        begin
            if (pred_win[i] == cstt_pkg::CH_LF)
            begin
                if (p_line != LINE_MAX)
                    p_line = p_line + LB'(1);
                p_col = CB'(1);
            end
            else
                p_col = col_plus(p_col, 1);
        end
        for (i = 0; i < WD; i++)
            pred_win[i] = (i + m < WD) ? pred_win[i + m] : 8'h00;
        win_cnt = win_cnt - m;
    endfunction

    function automatic void decide_head(input int avail);
        logic [7:0] m;
        logic [7:0] r;
        m = trigraph_char(pred_win[2]);
        if (tri_en && avail >= 3 && pred_win[0] == cstt_pkg::CH_QMARK
            && pred_win[1] == cstt_pkg::CH_QMARK && m != cstt_pkg::CH_NUL)
        begin
            p_seen = 1'b1;
            if (m == cstt_pkg::CH_BSL && avail >= 4 && pred_win[3] == cstt_pkg::CH_LF)
            begin
                shift_out(4);
                return;
            end
            if (m == cstt_pkg::CH_BSL && avail >= 5 && pred_win[3] == cstt_pkg::CH_CR
                && pred_win[4] == cstt_pkg::CH_LF)
            begin
                shift_out(5);
                return;
            end
            add_result(m, p_col, 1'b0, 1'b0);
            shift_out(3);
            return;
        end
        if (pred_win[0] == cstt_pkg::CH_BSL && avail >= 2)
        begin
            if (pred_win[1] == cstt_pkg::CH_LF)
            begin
                shift_out(2);
                return;
            end
            if (pred_win[1] == cstt_pkg::CH_CR && avail >= 3 && pred_win[2] == cstt_pkg::CH_LF)
            begin
                shift_out(3);
                return;
            end
        end
        if (avail >= 4 && pred_win[0] == cstt_pkg::CH_PERCENT
            && pred_win[1] == cstt_pkg::CH_COLON && pred_win[2] == cstt_pkg::CH_PERCENT
            && pred_win[3] == cstt_pkg::CH_COLON)
        begin
            add_result(cstt_pkg::CH_HASH, p_col, 1'b0, 1'b0);
            add_result(cstt_pkg::CH_HASH, col_plus(p_col, 2), 1'b0, 1'b0);
            shift_out(4);
            return;
        end
        if (avail >= 2)
        begin
            r = cstt_pkg::CH_NUL;
            if (pred_win[0] == cstt_pkg::CH_PERCENT && pred_win[1] == cstt_pkg::CH_COLON)
                r = cstt_pkg::CH_HASH;
            else if (pred_win[0] == cstt_pkg::CH_LT && pred_win[1] == cstt_pkg::CH_COLON)
                r = cstt_pkg::CH_LBRACK;
            else if (pred_win[0] == cstt_pkg::CH_COLON && pred_win[1] == cstt_pkg::CH_GT)
                r = cstt_pkg::CH_RBRACK;
            else if (pred_win[0] == cstt_pkg::CH_LT && pred_win[1] == cstt_pkg::CH_PERCENT)
                r = cstt_pkg::CH_LBRACE;
            else if (pred_win[0] == cstt_pkg::CH_PERCENT && pred_win[1] == cstt_pkg::CH_GT)
                r = cstt_pkg::CH_RBRACE;
            if (r != cstt_pkg::CH_NUL)
            begin
                add_result(r, p_col, 1'b0, 1'b0);
                shift_out(2);
                return;
            end
        end
        add_result(pred_win[0], p_col, 1'b0, 1'b0);
        shift_out(1);
    endfunction

    function automatic void translate_item(input cstt_pkg::in_item_t it);
        int i;
        cstt_pkg::result_t r;
        step_res.delete();
        if (it.end_of_source)
        begin
            while (win_cnt > 0)
                decide_head(win_cnt);
            add_result(cstt_pkg::CH_NUL, p_col, 1'b1, p_seen);
            if (p_seen)
                seen_terms++;
            sources_done++;
            pred_win = '{default: 8'h00};
            win_cnt  = 0;
            p_line   = LB'(1);
            p_col    = CB'(1);
            p_seen   = 1'b0;
        end
        else
        begin
            if (win_cnt < WD)
            begin
                pred_win[win_cnt] = it.src_byte;
                win_cnt++;
            end
            if (win_cnt >= WD)
                decide_head(WD);
        end
        for (i = 0; i < step_res.size(); i++)
        begin
            r = step_res[i];
            r.last_of_run = (i == step_res.size() - 1);
            translated_q.push_back(r);
        end
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else if (!(push && full))
        begin
            if (push)
            begin
                translate_item(src);
                items_accepted++;
            end
            if (drv_gap > 0)
            begin
                push <= 1'b0;
                drv_gap--;
            end
            else if (pending_q.size() > 0)
            begin
                push <= 1'b1;
                src  <= pending_q.pop_front();
                drv_gap = idle_len();
            end
            else
                push <= 1'b0;
        end
    end

    // one long receiver hold-off, armed once by the stimulus
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_arm && !hold_done)
            begin
                hold_done <= 1'b1;
                hold_cnt  <= 150;
            end
            else if (hold_cnt > 0)
                hold_cnt <= hold_cnt - 1;
        end
    end

    // result checker and pop control
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (translated_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("ERROR: unexpected result byte=%h line=%0d col=%0d term=%b",
                                 result.out_byte, result.raw_line, result.raw_column,
                                 result.is_terminator);
                end
                else
                begin
                    cstt_pkg::result_t want;
                    want = translated_q.pop_front();
                    results_checked++;
                    if (result !== want)
                    begin
                        err_count++;
                        if (err_count <= 10)
                        begin
                            $display("ERROR: result %0d exp byte %h line %0d col %0d %s",
                                     results_checked, want.out_byte, want.raw_line,
                                     want.raw_column,
                                     $sformatf("term %b seen %b last %b",
                                               want.is_terminator, want.trigraph_seen,
                                               want.last_of_run));
                            $display("       act byte %h line %0d col %0d term %b seen %b last %b",
                                     result.out_byte, result.raw_line, result.raw_column,
                                     result.is_terminator, result.trigraph_seen,
                                     result.last_of_run);
                        end
                    end
                end
            end
            if (hold_cnt > 0)
                pop <= 1'b0;
            else if (rcv_gap > 0)
            begin
                pop <= 1'b0;
                rcv_gap--;
            end
            else
            begin
                pop <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    rcv_gap = idle_len();
            end
        end
    end

    task automatic add_byte(input logic [7:0] b);
        cstt_pkg::in_item_t it;
        it.src_byte      = b;
        it.end_of_source = 1'b0;
        pending_q.push_back(it);
        queued++;
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic add_end();
        cstt_pkg::in_item_t it;
        it.src_byte      = 8'($urandom_range(0, 255));
        it.end_of_source = 1'b1;
        pending_q.push_back(it);
        queued++;
    endtask

    task automatic add_random_token();
        int k;
        k = $urandom_range(0, 19);
        case (k)
            0:
            begin
                add_text("??");
                add_byte(tri_keys[$urandom_range(0, 8)]);
            end
            1:
            begin
                add_text("??");
                add_byte(8'($urandom_range(0, 255)));
            end
            2:
                add_text("??/\n");
            3:
            begin
                add_text("??/");
                add_byte(cstt_pkg::CH_CR);
                add_byte(cstt_pkg::CH_LF);
            end
            4:
                add_text("\\\n");
            5:
            begin
                add_byte(cstt_pkg::CH_BSL);
                add_byte(cstt_pkg::CH_CR);
                add_byte(cstt_pkg::CH_LF);
            end
            6:
                add_text("%:%:");
            7:
            begin
                k = $urandom_range(0, 4);
                add_byte(digraph_text[k][0]);
                add_byte(digraph_text[k][1]);
            end
            8:
                add_byte(cstt_pkg::CH_LF);
            9:
                add_byte(cstt_pkg::CH_CR);
            10:
                add_byte(cstt_pkg::CH_QMARK);
            11:
                add_byte(cstt_pkg::CH_BSL);
            12, 13:
                add_byte(8'($urandom_range(0, 255)));
            default:
                add_byte(8'($urandom_range(8'h61, 8'h7A)));
        endcase
    endtask

    task automatic add_random_source(input bit with_end);
        int n;
        int i;
        n = $urandom_range(0, 12);
        if ($urandom_range(0, 9) == 0)
        begin
            // noise source
            for (i = 0; i < n; i++)
                add_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            for (i = 0; i < n; i++)
                add_random_token();
        end
        if (with_end)
            add_end();
    endtask

    // sample at the falling edge so the driver's updates are settled
    task automatic wait_idle();
        @(negedge clk);
        while (pending_q.size() != 0 || push || translated_q.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_trigraph_enable(input bit v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        tri_en = v;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    initial
    begin
        int start;
        int i;
        int n;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // translation off: empty source, trigraph and digraph, byte extremes
        add_end();
        add_text("??=%:");
        add_byte(8'h00);
        add_byte(8'hFF);
        add_text("??/\n");
        add_end();
        wait_idle();
        write_trigraph_enable(1'b0);

        write_trigraph_enable(1'b1);
        add_text("??=??/\n??/");
        add_byte(cstt_pkg::CH_CR);
        add_byte(cstt_pkg::CH_LF);
        add_text("??x\\\n\\");
        add_byte(cstt_pkg::CH_CR);
        add_byte(cstt_pkg::CH_LF);
        add_text("<:%>");
        add_end();
        add_text("??");
        add_end();
        wait_idle();

        // steady burst while the receiver holds off: queue fills, full backs up
        steady   = 1'b1;
        hold_arm = 1'b1;
        for (i = 0; i < 40; i++)
            add_byte(8'($urandom_range(8'h61, 8'h7A)));
        add_text("%:%:ab");
        add_end();
        wait_idle();
        steady = 1'b0;

        start = queued;
        while (queued - start < RANDOM_ITEMS)
        begin
            steady = ($urandom_range(0, 3) == 0);
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
                add_random_source((i < n - 1) || ($urandom_range(0, 3) != 0));
            wait_idle();
            write_trigraph_enable(1'($urandom_range(0, 1)));
        end
        steady = 1'b0;
        add_end();
        wait_idle();

        $display("Run covered %0d items in %0d sources, %0d results checked, %0d config writes.",
                 items_accepted, sources_done, results_checked, cfg_writes);
        $display("%0d terminators flagged a trigraph; %0d mismatches.", seen_terms, err_count);
        if (err_count == 0)
            $display("PASS c_source_trigraph_splice_translator_top");
        else
            $display("FAIL c_source_trigraph_splice_translator_top");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Timeout with %0d results still expected.", translated_q.size());
        $display("FAIL c_source_trigraph_splice_translator_top");
        $finish;
    end

endmodule
